@@ hw/rtl/free_block_bitmap_assert.svh @@
// Assertion macros used by the checker of the free block bitmap.
// Needs nothing else; each macro expects a clock and an active-low reset.
`ifndef FREE_BLOCK_BITMAP_ASSERT_SVH
`define FREE_BLOCK_BITMAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("free_block_bitmap assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("free_block_bitmap assertion failed");

`endif

@@ hw/rtl/fbb_pkg.sv @@
// Shared types and constants of the free block bitmap.
// Used by the controller, the datapath and the top level; depends on nothing.
package fbb_pkg;

    localparam int BYTE_BITS = 8;

    localparam logic [1:0] KIND_CHECK = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LIST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_LIST,
        ST_RECOUNT
    } fbb_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic item_load;
        logic cfg_load;
        logic single_fire;
        logic list_fire;
        logic none_fire;
        logic row_advance;
        logic rc_accum;
    } fbb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic row_has_free;
        logic count_zero;
        logic list_last;
        logic rc_done;
    } fbb_stat_t;

endpackage

@@ hw/rtl/fbb_controller.sv @@
// Sequencing state machine of the free block bitmap.
// Depends on fbb_pkg; drives the datapath through fbb_cmd_t commands.
module fbb_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        kind,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  fbb_pkg::fbb_stat_t stat,
    output fbb_pkg::fbb_cmd_t  cmd
);
    import fbb_pkg::*;

    fbb_state_t state_reg;
    fbb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (cfg_valid)
                begin
                    cmd.cfg_load = 1'b1;
                    state_next   = ST_RECOUNT;
                end
                else if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = (kind == KIND_LIST) ? ST_LIST : ST_SINGLE;
                end
            end
            ST_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.single_fire = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                if (stat.count_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.none_fire = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (stat.row_has_free)
                begin
                    if (stat.out_free)
                    begin
                        cmd.list_fire = 1'b1;
                        if (stat.list_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.row_advance = 1'b1;
                end
            end
            ST_RECOUNT:
            begin
                cmd.rc_accum = 1'b1;
                if (stat.rc_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/fbb_datapath.sv @@
// Map memory, free counter, list scanner and output register of the free block bitmap.
// Depends on fbb_pkg; obeys fbb_cmd_t commands from fbb_controller.
module fbb_datapath #(
    parameter int MAX_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fbb_pkg::fbb_cmd_t  cmd,
    output fbb_pkg::fbb_stat_t stat,
    input  logic [1:0]         kind,
    input  logic [5:0]         bit_index,
    input  logic               write_value,
    input  logic [3:0]         active_bytes,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               bit_value,
    output logic [5:0]         free_index,
    output logic               found,
    output logic [6:0]         free_count,
    output logic               out_of_range,
    output logic               last
);
    import fbb_pkg::*;

    localparam int ROWS = MAX_BYTES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [3:0] MAX_B = 4'(MAX_BYTES);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [BYTE_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]      row_vld_reg;
    logic [BYTE_BITS-1:0] rdata_reg;

    logic [1:0]           item_kind_reg;
    logic [5:0]           item_idx_reg;
    logic                 item_wv_reg;
    logic [3:0]           active_reg;
    logic [6:0]           count_reg;
    logic [6:0]           count_next;
    logic [ROW_W-1:0]     row_ptr_reg;
    logic [BYTE_BITS-1:0] taken_reg;
    logic [6:0]           emit_cnt_reg;

    logic                 out_valid_reg;
    logic                 bit_value_reg;
    logic [5:0]           free_index_reg;
    logic                 found_reg;
    logic [6:0]           free_count_reg;
    logic                 oor_reg;
    logic                 last_reg;

    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    logic [BYTE_BITS-1:0] wr_data;
    logic                 oor;
    logic                 cur_bit;
    logic [BYTE_BITS-1:0] free_bits;
    logic [2:0]           low_idx;
    logic [3:0]           row_free;
    logic                 in_active;
    logic [3:0]           cfg_clamped;
    logic                 fire;

    assign oor       = {1'b0, item_idx_reg} >= {active_reg, 3'b000};
    assign cur_bit   = rdata_reg[item_idx_reg[2:0]];
    assign free_bits = ~rdata_reg & ~taken_reg;
    assign in_active = 4'(row_ptr_reg) < active_reg;
    assign wr_en     = cmd.single_fire && (item_kind_reg == KIND_WRITE) && !oor;
    assign wr_addr   = item_idx_reg[3 +: ROW_W];
    assign fire      = cmd.single_fire || cmd.list_fire || cmd.none_fire;

    always_comb
    begin
        wr_data = rdata_reg;
        wr_data[item_idx_reg[2:0]] = item_wv_reg;
    end

    // Lowest free bit of the current row that has not been listed yet.
    always_comb
    begin
        low_idx = 3'd0;
        for (int i = BYTE_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                low_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        row_free = 4'd0;
        for (int i = 0; i < BYTE_BITS; i++)
        begin
            row_free = row_free + {3'd0, ~rdata_reg[i]};
        end
    end

    always_comb
    begin
        if (active_bytes == 4'd0)
        begin
            cfg_clamped = 4'd1;
        end
        else if (active_bytes > MAX_B)
        begin
            cfg_clamped = MAX_B;
        end
        else
        begin
            cfg_clamped = active_bytes;
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.item_load)
        begin
            rd_en   = 1'b1;
            rd_addr = (kind == KIND_LIST) ? '0 : bit_index[3 +: ROW_W];
        end
        else if (cmd.cfg_load)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.row_advance || cmd.rc_accum)
        begin
            rd_en   = 1'b1;
            rd_addr = row_ptr_reg + ROW_W'(1);
        end
    end

    // The free count is kept exact: set by a recount pass, stepped on each in-range write that changes a bit.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.cfg_load)
        begin
            count_next = '0;
        end
        else if (cmd.rc_accum && in_active)
        begin
            count_next = count_reg + 7'(row_free);
        end
        else if (wr_en && (cur_bit != item_wv_reg))
        begin
            count_next = item_wv_reg ? count_reg - 7'd1 : count_reg + 7'd1;
        end
    end

    // Rows never written read as all in use.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= row_vld_reg[rd_addr] ? mem[rd_addr] : {BYTE_BITS{1'b1}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_kind_reg <= kind;
            item_idx_reg  <= bit_index;
            item_wv_reg   <= write_value;
        end
        if (fire)
        begin
            bit_value_reg  <= 1'b0;
            free_index_reg <= '0;
            found_reg      <= 1'b0;
            free_count_reg <= count_reg;
            oor_reg        <= 1'b0;
            last_reg       <= 1'b1;
            if (cmd.single_fire)
            begin
                bit_value_reg  <= (item_kind_reg == KIND_CHECK) && !oor && cur_bit;
                free_count_reg <= count_next;
                oor_reg        <= ((item_kind_reg == KIND_CHECK) ||
                                   (item_kind_reg == KIND_WRITE)) && oor;
            end
            if (cmd.list_fire)
            begin
                free_index_reg <= 6'({row_ptr_reg, low_idx});
                found_reg      <= 1'b1;
                last_reg       <= stat.list_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= '0;
            active_reg    <= MAX_B;
            count_reg     <= '0;
            row_ptr_reg   <= '0;
            taken_reg     <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.cfg_load)
            begin
                active_reg <= cfg_clamped;
            end
            count_reg <= count_next;
            if (cmd.item_load || cmd.cfg_load)
            begin
                row_ptr_reg <= '0;
                taken_reg   <= '0;
            end
            else if (cmd.row_advance || cmd.rc_accum)
            begin
                row_ptr_reg <= row_ptr_reg + ROW_W'(1);
                taken_reg   <= '0;
            end
            else if (cmd.list_fire)
            begin
                taken_reg <= taken_reg | (BYTE_BITS'(1) << low_idx);
            end
            if (cmd.item_load)
            begin
                emit_cnt_reg <= '0;
            end
            else if (cmd.list_fire)
            begin
                emit_cnt_reg <= emit_cnt_reg + 7'd1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free     = !out_valid_reg || out_ready;
    assign stat.row_has_free = |free_bits;
    assign stat.count_zero   = (count_reg == 7'd0);
    assign stat.list_last    = ((emit_cnt_reg + 7'd1) == count_reg);
    assign stat.rc_done      = (row_ptr_reg == LAST_ROW);

    assign out_valid    = out_valid_reg;
    assign bit_value    = bit_value_reg;
    assign free_index   = free_index_reg;
    assign found        = found_reg;
    assign free_count   = free_count_reg;
    assign out_of_range = oor_reg;
    assign last         = last_reg;

endmodule

@@ hw/rtl/free_block_bitmap.sv @@
// Free block bitmap: usage map of MAX_BYTES*8 blocks with check, write and list.
// Top level; instantiates fbb_controller and fbb_datapath, uses fbb_pkg.
//
// Usage: an input transaction (kind, bit_index, write_value) is taken when
// in_valid and in_ready are high. A check or write returns one result; its
// result register is loaded once the output register is free, and the next
// item is taken after that.
// A list returns one result per free block in ascending order, the last one
// marked, or one result with found low when nothing is free. Free indices
// within one map byte come out one per cycle unless the receiver stalls; each
// map byte without a free bit left costs an extra one-byte map memory read.
// A write on the cfg channel sets active_bytes; the block then recounts the
// free blocks, one map byte per cycle, and holds in_ready low until the pass ends.
// After reset every block is in use, the free count is zero and all
// MAX_BYTES bytes are active. When the receiver holds out_ready low, the
// result stays in the output register and the block waits for it.
module free_block_bitmap #(
    parameter int MAX_BYTES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [5:0] bit_index,
    input  logic       write_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] active_bytes,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       bit_value,
    output logic [5:0] free_index,
    output logic       found,
    output logic [6:0] free_count,
    output logic       out_of_range,
    output logic       last
);
    import fbb_pkg::*;

    fbb_cmd_t  cmd;
    fbb_stat_t stat;

    fbb_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fbb_datapath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .bit_index    (bit_index),
        .write_value  (write_value),
        .active_bytes (active_bytes),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .bit_value    (bit_value),
        .free_index   (free_index),
        .found        (found),
        .free_count   (free_count),
        .out_of_range (out_of_range),
        .last         (last)
    );

endmodule

@@ hw/rtl/fbb_checker.sv @@
// Port-level checker of the free block bitmap and its bind to the top level.
// Depends on free_block_bitmap_assert.svh for the assertion macros.
`include "free_block_bitmap_assert.svh"

module fbb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       bit_value,
    input logic [5:0] free_index,
    input logic       found,
    input logic [6:0] free_count,
    input logic       out_of_range,
    input logic       last
);

    logic [16:0] out_word;
    logic        found_clean;
    logic        oor_clean;

    assign out_word    = {bit_value, free_index, found, free_count, out_of_range, last};
    assign found_clean = !out_of_range && !bit_value && (free_count != 7'd0);
    assign oor_clean   = last && !found && !bit_value;

    // A stalled result holds its whole payload.
    `FBB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

    // A listed free index never comes with check or range flags.
    `FBB_ASSERT_IMP(a_found_clean, clk, rst_n, out_valid && found, found_clean)

    // An out-of-range answer is always a single, final result.
    `FBB_ASSERT_IMP(a_oor_single, clk, rst_n, out_valid && out_of_range, oor_clean)

    // Configuration and items are never taken in the same cycle.
    `FBB_ASSERT_IMP(a_cfg_item_excl, clk, rst_n, in_valid && in_ready, !(cfg_valid && cfg_ready))

endmodule

bind free_block_bitmap fbb_checker u_fbb_checker (.*);

@@ tb/tb_free_block_bitmap.sv @@
// Self-checking testbench for the free block bitmap: check, write and list
// transactions under random sender gaps and receiver stalls, with active_bytes changes.
// Depends on fbb_pkg and free_block_bitmap; everything else lives in this file.
`timescale 1ns / 100ps

module tb_free_block_bitmap;
    import fbb_pkg::*;

    localparam int MAP_BYTES = 8;
    localparam int MAP_BLOCKS = MAP_BYTES * 8;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        logic       bit_value;
        logic [5:0] free_index;
        logic       found;
        logic [6:0] free_count;
        logic       out_of_range;
        logic       last;
    } map_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] kind;
    logic [5:0] bit_index;
    logic       write_value;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] active_bytes;
    logic       out_valid;
    logic       out_ready;
    logic       bit_value;
    logic [5:0] free_index;
    logic       found;
    logic [6:0] free_count;
    logic       out_of_range;
    logic       last;

    // Predictor state: the usage map and the active length in blocks.
    logic [MAP_BLOCKS-1:0] usage_bits;
    int unsigned           active_blocks;
    map_result_t           expected_map_results[$];

    int mismatch_count = 0;
    int items_sent = 0;
    int lists_sent = 0;
    int results_checked = 0;
    int configs_written = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int mode_left = 0;
    int ready_pct = 100;

    free_block_bitmap #(
        .MAX_BYTES(MAP_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .bit_index(bit_index),
        .write_value(write_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .active_bytes(active_bytes),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .bit_value(bit_value),
        .free_index(free_index),
        .found(found),
        .free_count(free_count),
        .out_of_range(out_of_range),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTED)
                $display("mismatch at %0t ns, result %0d: %s got %0d expected %0d",
                         $time, results_checked, what, got, want);
        end
    endtask

    function automatic logic [6:0] count_free_blocks();
        int n;
        begin
            n = 0;
            for (int i = 0; i < active_blocks; i++)
                if (!usage_bits[i])
                    n++;
            return n[6:0];
        end
    endfunction

    // Appends one expected result at the tail of the queue.
    function automatic void queue_expected(input map_result_t res);
        begin
            expected_map_results.insert(expected_map_results.size(), res);
        end
    endfunction

    // Updates the map for one accepted transaction and queues the results it causes.
    function automatic void apply_map_item(input logic [1:0] k, input logic [5:0] idx,
                                           input logic wv);
        map_result_t r;
        logic        beyond;
        logic [6:0]  nfree;
        int          emitted;
        begin
            r = '0;
            r.last = 1'b1;
            beyond = (idx >= active_blocks);
            case (k)
                KIND_CHECK:
                begin
                    r.bit_value = beyond ? 1'b0 : usage_bits[idx];
                    r.out_of_range = beyond;
                    r.free_count = count_free_blocks();
                    queue_expected(r);
                end
                KIND_WRITE:
                begin
                    if (!beyond)
                        usage_bits[idx] = wv;
                    r.out_of_range = beyond;
                    r.free_count = count_free_blocks();
                    queue_expected(r);
                end
                KIND_LIST:
                begin
                    nfree = count_free_blocks();
                    r.free_count = nfree;
                    if (nfree == 0)
                        queue_expected(r);
                    emitted = 0;
                    for (int i = 0; i < active_blocks; i++)
                    begin
                        if (!usage_bits[i])
                        begin
                            emitted++;
                            r.free_index = i[5:0];
                            r.found = 1'b1;
                            r.last = (emitted == nfree);
                            queue_expected(r);
                        end
                    end
                end
                default:
                begin
                    r.free_count = count_free_blocks();
                    queue_expected(r);
                end
            endcase
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_map_item(input logic [1:0] k, input logic [5:0] idx, input logic wv);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = gaps_on ? $urandom_range(0, 6) : 0;
                burst_left = $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            in_valid <= 1'b1;
            kind <= k;
            bit_index <= idx;
            write_value <= wv;
            do @(posedge clk); while (!in_ready);
            apply_map_item(k, idx, wv);
            items_sent++;
            if (k == KIND_LIST)
                lists_sent++;
            @(negedge clk);
        end
    endtask

    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            while (expected_map_results.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // Only called with the block idle, right after drain_results.
    task automatic write_active_bytes(input logic [3:0] nbytes);
        begin
            cfg_valid <= 1'b1;
            active_bytes <= nbytes;
            do @(posedge clk); while (!cfg_ready);
            if (nbytes == 0)
                active_blocks = 8;
            else if (nbytes > MAP_BYTES)
                active_blocks = MAP_BLOCKS;
            else
                active_blocks = nbytes * 8;
            configs_written++;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic reconfigure(input logic [3:0] nbytes);
        begin
            drain_results();
            write_active_bytes(nbytes);
        end
    endtask

    function automatic logic [5:0] pick_index();
        begin
            if ($urandom_range(0, 99) < 85)
                return 6'($urandom_range(0, active_blocks - 1));
            return 6'($urandom_range(0, MAP_BLOCKS - 1));
        end
    endfunction

    task automatic test_reset_state();
        begin
            send_map_item(KIND_CHECK, 6'd0, 1'b0);
            send_map_item(KIND_CHECK, 6'd63, 1'b1);
            send_map_item(KIND_LIST, 6'd0, 1'b0);
            send_map_item(KIND_SPARE, 6'd42, 1'b1);
            drain_results();
        end
    endtask

    task automatic test_single_ops();
        begin
            send_map_item(KIND_WRITE, 6'd0, 1'b0);
            send_map_item(KIND_WRITE, 6'd63, 1'b0);
            send_map_item(KIND_WRITE, 6'd5, 1'b0);
            send_map_item(KIND_CHECK, 6'd0, 1'b0);
            send_map_item(KIND_CHECK, 6'd63, 1'b0);
            send_map_item(KIND_LIST, 6'd21, 1'b1);
            send_map_item(KIND_WRITE, 6'd5, 1'b1);
            send_map_item(KIND_CHECK, 6'd5, 1'b0);
            drain_results();
        end
    endtask

    // Shrinks the map to one byte, then tries the zero and oversized settings.
    task automatic test_active_length();
        begin
            reconfigure(4'd1);
            send_map_item(KIND_WRITE, 6'd8, 1'b0);
            send_map_item(KIND_CHECK, 6'd63, 1'b0);
            send_map_item(KIND_WRITE, 6'd7, 1'b0);
            send_map_item(KIND_LIST, 6'd0, 1'b0);
            reconfigure(4'd0);
            send_map_item(KIND_CHECK, 6'd7, 1'b0);
            reconfigure(4'd15);
            send_map_item(KIND_CHECK, 6'd63, 1'b0);
            send_map_item(KIND_LIST, 6'd63, 1'b0);
            drain_results();
        end
    endtask

    // The receiver stops for a long stretch while lists and checks keep arriving, so the
    // output register and then the input side have to stall.
    task automatic test_output_stall();
        begin
            reconfigure(4'd8);
            gaps_on = 1'b0;
            for (int i = 0; i < 12; i++)
                send_map_item(KIND_WRITE, 6'($urandom_range(0, 63)), 1'b0);
            hold_requests++;
            for (int i = 0; i < 8; i++)
                send_map_item((i % 2 == 0) ? KIND_LIST : KIND_CHECK,
                              6'($urandom_range(0, 63)), 1'b0);
            gaps_on = 1'b1;
            drain_results();
        end
    endtask

    task automatic test_random_traffic();
        logic [3:0] setting;
        int         pick;
        logic [1:0] k;
        begin
            for (int phase = 0; phase < 10; phase++)
            begin
                case (phase)
                    0: setting = 4'd8;
                    1: setting = 4'd1;
                    2: setting = 4'd0;
                    3: setting = 4'd12;
                    9: setting = 4'd8;
                    default: setting = 4'($urandom_range(0, 15));
                endcase
                reconfigure(setting);
                gaps_on = ($urandom_range(0, 3) != 0);
                for (int n = 0; n < 33; n++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)
                        k = KIND_WRITE;
                    else if (pick < 75)
                        k = KIND_CHECK;
                    else if (pick < 94)
                        k = KIND_LIST;
                    else
                        k = KIND_SPARE;
                    send_map_item(k, pick_index(), 1'($urandom_range(0, 1)));
                end
            end
            drain_results();
        end
    endtask

    // Receiver: switches between stall patterns and serves long hold requests.
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (mode_left == 0)
        begin
            mode_left = $urandom_range(16, 96);
            case ($urandom_range(0, 2))
                0: ready_pct = 100;
                1: ready_pct = 70;
                default: ready_pct = 25;
            endcase
        end
        mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        map_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (expected_map_results.size() == 0)
            begin
                report_mismatch("unexpected result, free_index", free_index, 0);
            end
            else
            begin
                want = expected_map_results.pop_front();
                if (bit_value !== want.bit_value)
                    report_mismatch("bit_value", bit_value, want.bit_value);
                if (free_index !== want.free_index)
                    report_mismatch("free_index", free_index, want.free_index);
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                if (free_count !== want.free_count)
                    report_mismatch("free_count", free_count, want.free_count);
                if (out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", out_of_range, want.out_of_range);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    initial
    begin
        #20000000;
        $display("timeout at %0t ns", $time);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_CHECK;
        bit_index = 6'd0;
        write_value = 1'b0;
        cfg_valid = 1'b0;
        active_bytes = 4'd8;
        out_ready = 1'b0;
        usage_bits = '1;
        active_blocks = MAP_BLOCKS;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_single_ops();
        test_active_length();
        test_output_stall();
        test_random_traffic();

        if (expected_map_results.size() != 0)
            report_mismatch("results never delivered", 0, expected_map_results.size());
        $display("covered %0d transactions (%0d lists), %0d results, %0d active_bytes writes",
                 items_sent, lists_sent, results_checked, configs_written);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/fbb_pkg.sv
hw/rtl/fbb_controller.sv
hw/rtl/fbb_datapath.sv
hw/rtl/free_block_bitmap.sv
hw/rtl/fbb_checker.sv
tb/tb_free_block_bitmap.sv
